>>> rtl/core/fsls_pkg.sv
`timescale 1ns / 1ps

package fsls_pkg;

  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned RATE_W    = 15;
  localparam int unsigned STEP_W    = 17;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned BACKLOG_W = 20;
  localparam int unsigned ACC_W     = 21;
  localparam int unsigned SMOOTH_W  = 24;
  localparam int unsigned MUL_A_W   = 24;
  localparam int unsigned MUL_B_W   = 17;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;

  // 100 ms frame time limit, 720 deg/s rate limit, 2 deg/s dead zone,
  // (30 deg/s)^2 speed threshold, the rates in 1/16 deg/s units
  localparam logic [STEP_W-1:0] DT_CLAMP_US = 17'd100000;
  localparam logic [24:0]       RATE_LIMIT  = 25'd11520;
  localparam logic [24:0]       DEAD_ZONE   = 25'd32;
  localparam logic [28:0]       FAST_SQ     = 29'd230400;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;

  // register indexes
  localparam logic [1:0] REG_STEP_US    = 2'd0;
  localparam logic [1:0] REG_RATE_SCALE = 2'd1;
  localparam logic [1:0] REG_ALPHA_MOVE = 2'd2;
  localparam logic [1:0] REG_ALPHA_STOP = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED,
    OP_CUT,
    OP_MUL_Y,
    OP_MUL_P,
    OP_SQ_Y,
    OP_SQ_P,
    OP_SEL,
    OP_BL_Y,
    OP_BL_P,
    OP_BL_DONE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic step_ok;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_us;
    logic [SCALE_W-1:0] rate_scale;
    logic [ALPHA_W-1:0] alpha_move;
    logic [ALPHA_W-1:0] alpha_stop;
  } cfg_t;

endpackage

>>> rtl/core/fsls_ctrl.sv
`timescale 1ns / 1ps

module fsls_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fsls_pkg::status_t status_i,
  output fsls_pkg::cmd_t    cmd_o
);
  import fsls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_Y,
    S_MUL_P,
    S_SQ_Y,
    S_SQ_P,
    S_SEL,
    S_BL_Y,
    S_BL_P,
    S_BL_DONE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.step_ok) begin
          cmd_o.op = OP_SEED;
          state_d  = S_MUL_Y;
        end else begin
          cmd_o.op = OP_CUT;
          state_d  = S_IDLE;
        end
      end
      S_MUL_Y: begin
        cmd_o.op = OP_MUL_Y;
        state_d  = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.op = OP_MUL_P;
        state_d  = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_SQ_P;
      end
      S_SQ_P: begin
        cmd_o.op = OP_SQ_P;
        state_d  = S_SEL;
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        state_d  = S_BL_Y;
      end
      S_BL_Y: begin
        cmd_o.op = OP_BL_Y;
        state_d  = S_BL_P;
      end
      S_BL_P: begin
        cmd_o.op = OP_BL_P;
        state_d  = S_BL_DONE;
      end
      S_BL_DONE: begin
        cmd_o.op = OP_BL_DONE;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> rtl/core/fsls_dp.sv
`timescale 1ns / 1ps

module fsls_dp #(
  parameter int unsigned MAX_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fsls_pkg::cfg_t                     cfg_i,
  input  fsls_pkg::cmd_t                     cmd_i,
  output fsls_pkg::status_t                  status_o,
  input  logic [fsls_pkg::ELAPSED_W-1:0]     in_elapsed_i,
  input  logic [fsls_pkg::ANGLE_W-1:0]       in_yaw_i,
  input  logic [fsls_pkg::ANGLE_W-1:0]       in_pitch_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fsls_pkg::RATE_W-1:0]        out_yaw_o,
  output logic [fsls_pkg::RATE_W-1:0]        out_pitch_o,
  output logic                               out_last_o
);
  import fsls_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

  // wrapped angle change: {negative, magnitude}; a half turn counts positive
  function automatic logic [17:0] wrap_mag(input logic [15:0] w);
    logic [15:0] n;
    n = 16'(~w + 16'd1);
    if (w[15] && (w[14:0] != 15'd0)) begin
      wrap_mag = {1'b1, 1'b0, n};
    end else begin
      wrap_mag = {1'b0, 1'b0, w};
    end
  endfunction

  // round, clamp and dead-zone a rate magnitude from |d| * scale in Q8
  function automatic logic [13:0] rate_mag(input logic [32:0] p);
    logic [32:0] s;
    logic [24:0] r;
    s = p + 33'd128;
    r = s[32:8];
    if (r > RATE_LIMIT) begin
      r = RATE_LIMIT;
    end
    if (r < DEAD_ZONE) begin
      r = 25'd0;
    end
    rate_mag = r[13:0];
  endfunction

  // add the rounded blend correction to a smoothed rate
  function automatic logic [SMOOTH_W-1:0] blend_add(input logic [SMOOTH_W-1:0] s,
                                                    input logic [PROD_W-1:0] p,
                                                    input logic neg);
    logic [PROD_W-1:0] t;
    logic [24:0]       r;
    logic [24:0]       sum;
    t = p + PROD_W'(32768);
    r = t[40:16];
    if (neg) begin
      sum = {s[SMOOTH_W-1], s} - r;
    end else begin
      sum = {s[SMOOTH_W-1], s} + r;
    end
    blend_add = sum[SMOOTH_W-1:0];
  endfunction

  // {negative, magnitude} of ry*256 - s
  function automatic logic [24:0] diff_mag(input logic [RATE_W-1:0] r,
                                           input logic [SMOOTH_W-1:0] s);
    logic [24:0] d;
    logic [24:0] n;
    d = {{2{r[RATE_W-1]}}, r, 8'd0} - {s[SMOOTH_W-1], s};
    n = 25'(~d + 25'd1);
    diff_mag = d[24] ? {1'b1, n[23:0]} : {1'b0, d[23:0]};
  endfunction

  // round the Q8 smoothed rate to 1/16 deg/s, halves away from zero
  function automatic logic [RATE_W-1:0] out_rate(input logic [SMOOTH_W-1:0] s);
    logic [SMOOTH_W-1:0] m;
    logic [SMOOTH_W:0]   t;
    logic [RATE_W-1:0]   r;
    m = s[SMOOTH_W-1] ? SMOOTH_W'(~s + 24'd1) : s;
    t = {1'b0, m} + 25'd128;
    r = t[22:8];
    out_rate = s[SMOOTH_W-1] ? RATE_W'(~r + 15'd1) : r;
  endfunction

  logic [BACKLOG_W-1:0] backlog_q;
  logic                 seeded_q;
  logic [ANGLE_W-1:0]   prev_y_q, prev_p_q;
  logic [SMOOTH_W-1:0]  sy_q, sp_q;
  logic [ACC_W-1:0]     acc_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q;

  logic [ANGLE_W-1:0]   cur_y_q, cur_p_q;
  logic [16:0]          dmag_y_q, dmag_p_q;
  logic                 dneg_y_q, dneg_p_q;
  logic [RATE_W-1:0]    ry_q, rp_q;
  logic [13:0]          rymag_q, rpmag_q;
  logic [27:0]          sqy_q;
  logic                 fast_q;
  logic [23:0]          dfy_mag_q, dfp_mag_q;
  logic                 dfy_neg_q, dfp_neg_q;
  logic [PROD_W-1:0]    prod_q;
  logic [RATE_W-1:0]    out_yaw_q, out_pitch_q;
  logic                 out_last_q;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [ALPHA_W-1:0]   alpha_raw, alpha_eff;
  logic [STEP_W-1:0]    dt_clamped;
  logic [17:0]          wy, wp;
  logic [15:0]          dy, dp;
  logic [13:0]          rm_prod;
  logic [28:0]          sq_sum;
  logic [24:0]          dfy, dfp;
  logic [ACC_W-1:0]     step_ext;
  logic [ACC_W-1:0]     four_steps;
  logic                 out_free;

  assign step_ext   = ACC_W'(cfg_i.step_us);
  assign four_steps = ACC_W'({cfg_i.step_us, 2'b00});
  assign dt_clamped = (in_elapsed_i > ELAPSED_W'(DT_CLAMP_US)) ? DT_CLAMP_US
                                                               : in_elapsed_i[STEP_W-1:0];

  // later steps of one item see no change: prev already equals cur
  assign dy = seeded_q ? 16'(cur_y_q - prev_y_q) : 16'd0;
  assign dp = seeded_q ? 16'(cur_p_q - prev_p_q) : 16'd0;
  assign wy = wrap_mag(dy);
  assign wp = wrap_mag(dp);

  assign rm_prod = rate_mag(prod_q[32:0]);
  assign sq_sum  = {1'b0, sqy_q} + {1'b0, prod_q[27:0]};
  assign dfy     = diff_mag(ry_q, sy_q);
  assign dfp     = diff_mag(rp_q, sp_q);

  assign alpha_raw = fast_q ? cfg_i.alpha_move : cfg_i.alpha_stop;
  assign alpha_eff = alpha_raw[16] ? ALPHA_ONE : alpha_raw;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_Y: begin
        mul_a = MUL_A_W'(dmag_y_q);
        mul_b = MUL_B_W'(cfg_i.rate_scale);
      end
      OP_MUL_P: begin
        mul_a = MUL_A_W'(dmag_p_q);
        mul_b = MUL_B_W'(cfg_i.rate_scale);
      end
      OP_SQ_Y: begin
        mul_a = MUL_A_W'(rymag_q);
        mul_b = MUL_B_W'(rymag_q);
      end
      OP_SQ_P: begin
        mul_a = MUL_A_W'(rpmag_q);
        mul_b = MUL_B_W'(rpmag_q);
      end
      OP_BL_Y: begin
        mul_a = dfy_mag_q;
        mul_b = alpha_eff;
      end
      OP_BL_P: begin
        mul_a = dfp_mag_q;
        mul_b = alpha_eff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlog_q   <= '0;
      seeded_q    <= 1'b0;
      prev_y_q    <= '0;
      prev_p_q    <= '0;
      sy_q        <= '0;
      sp_q        <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces one that leaves at the same edge
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          acc_q <= ACC_W'(backlog_q) + ACC_W'(dt_clamped);
          cnt_q <= '0;
        end
        OP_SEED: begin
          prev_y_q <= cur_y_q;
          prev_p_q <= cur_p_q;
          seeded_q <= 1'b1;
          acc_q    <= acc_q - step_ext;
        end
        OP_CUT: begin
          if (acc_q > four_steps) begin
            backlog_q <= BACKLOG_W'({cfg_i.step_us, 1'b0});
          end else begin
            backlog_q <= acc_q[BACKLOG_W-1:0];
          end
        end
        OP_BL_P: begin
          sy_q <= blend_add(sy_q, prod_q, dfy_neg_q);
        end
        OP_BL_DONE: begin
          sp_q <= blend_add(sp_q, prod_q, dfp_neg_q);
        end
        OP_EMIT: begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // per-step payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_y_q <= in_yaw_i;
        cur_p_q <= in_pitch_i;
      end
      OP_SEED: begin
        dneg_y_q <= wy[17];
        dmag_y_q <= wy[16:0];
        dneg_p_q <= wp[17];
        dmag_p_q <= wp[16:0];
      end
      OP_MUL_P: begin
        rymag_q <= rm_prod;
        ry_q    <= dneg_y_q ? RATE_W'(~{1'b0, rm_prod} + 15'd1) : {1'b0, rm_prod};
      end
      OP_SQ_Y: begin
        rpmag_q <= rm_prod;
        rp_q    <= dneg_p_q ? RATE_W'(~{1'b0, rm_prod} + 15'd1) : {1'b0, rm_prod};
      end
      OP_SQ_P: begin
        sqy_q <= prod_q[27:0];
      end
      OP_SEL: begin
        fast_q    <= (sq_sum > FAST_SQ);
        dfy_neg_q <= dfy[24];
        dfy_mag_q <= dfy[23:0];
        dfp_neg_q <= dfp[24];
        dfp_mag_q <= dfp[23:0];
      end
      OP_EMIT: begin
        out_yaw_q   <= out_rate(sy_q);
        out_pitch_q <= out_rate(sp_q);
        out_last_q  <= (acc_q < step_ext) || (cnt_q == CNT_W'(MAX_STEPS - 1));
      end
      default: begin
      end
    endcase
  end

  assign out_free          = !out_valid_q || out_ready_i;
  assign status_o.out_free = out_free;
  assign status_o.step_ok  = (acc_q >= step_ext) && (cnt_q < CNT_W'(MAX_STEPS));

  assign out_valid_o = out_valid_q;
  assign out_yaw_o   = out_yaw_q;
  assign out_pitch_o = out_pitch_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/core/fixed_step_look_rate_smoother_core.sv
`timescale 1ns / 1ps

// Fixed-step look rate smoother. Each input item carries a frame time and the
// control yaw and pitch angles; the frame time (clamped to 100 ms) feeds a time
// backlog, and for every whole step in it, up to MAX_STEPS per item, the block
// emits one result item with the smoothed yaw and pitch rates in 1/16 deg/s,
// tlast marking the final step of that input. An item that runs no step gives
// no result. One item is worked at a time, and the work waits while the output
// side stalls. Each step makes six passes through the one shared 24x17
// multiplier (two rate scalings, two squares for the speed test, two blends)
// with their capture and emit states. The output register lets the next item
// be taken while the last result still waits. Configuration is over APB at
// byte addresses 0, 4, 8, 12 (step_us, rate_scale, alpha_move, alpha_stop)
// and must be written only while the block is idle.
module fixed_step_look_rate_smoother_core #(
  parameter int unsigned MAX_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [19:0] elapsed_us, [35:20] yaw_angle, [51:36] pitch_angle, [55:52] zero
  input  logic [55:0] s_axis_tdata_i,
  // result item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [14:0] yaw_rate, [29:15] pitch_rate, [31:30] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsls_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic [RATE_W-1:0] out_yaw;
  logic [RATE_W-1:0] out_pitch;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register file: write on the access cycle, drop bits above each width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_us    <= 17'd8333;
      cfg_q.rate_scale <= 16'd2700;
      cfg_q.alpha_move <= 17'd15892;
      cfg_q.alpha_stop <= 17'd6485;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_US:    cfg_q.step_us    <= pwdata[STEP_W-1:0];
        REG_RATE_SCALE: cfg_q.rate_scale <= pwdata[SCALE_W-1:0];
        REG_ALPHA_MOVE: cfg_q.alpha_move <= pwdata[ALPHA_W-1:0];
        REG_ALPHA_STOP: cfg_q.alpha_stop <= pwdata[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_US:    prdata = 32'(cfg_q.step_us);
      REG_RATE_SCALE: prdata = 32'(cfg_q.rate_scale);
      REG_ALPHA_MOVE: prdata = 32'(cfg_q.alpha_move);
      REG_ALPHA_STOP: prdata = 32'(cfg_q.alpha_stop);
      default:        prdata = '0;
    endcase
  end

  fsls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fsls_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_elapsed_i (s_axis_tdata_i[19:0]),
    .in_yaw_i     (s_axis_tdata_i[35:20]),
    .in_pitch_i   (s_axis_tdata_i[51:36]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_yaw_o    (out_yaw),
    .out_pitch_o  (out_pitch),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_pitch, out_yaw};

  // an accepted item keeps the input closed until its steps are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted again while an item is in work");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_EMIT) |-> status.out_free)
    else $error("result emitted over a waiting result");

  // the output valid only rises from an emit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.op == OP_EMIT))
    else $error("result valid without an emit");

endmodule
